// ----- hw/rtl/contour_command_decoder_unit_assert.svh -----
// Assertion shorthands used by the checker file ccd_checker.sv.
`ifndef CONTOUR_COMMAND_DECODER_UNIT_ASSERT_SVH
`define CONTOUR_COMMAND_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CCD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ccd_pkg.sv -----
package ccd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_EXT    = 2'd1,
    PH_CODES  = 2'd2,
    PH_COORDS = 2'd3
  } ccd_phase_t;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } ccd_cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NOT_CONTOUR = 2'd1,
    ERR_COUNT       = 2'd2
  } ccd_err_t;

  localparam logic [7:0] CNT_NOT_CONTOUR = 8'h80;
  localparam logic [7:0] CNT_EXTENDED    = 8'h40;
  localparam int         CODE_BYTE_CAP   = 255;
  localparam int         COORD_SLOTS     = 6;

endpackage

// ----- hw/rtl/contour_command_decoder_unit.sv -----
// Contour fragment decoder. Takes one fragment byte per cycle and returns one
// path command (kind, end point, up to two control points) once its last
// coordinate byte is in; a byte may be accepted every cycle unless a result
// is held on the output by out_stall, which stalls the input until it leaves,
// and a result appears on the output register the cycle after its last byte.
// The packed command codes are held in a code-byte memory of MAX_CODE_BYTES
// entries with a registered read port; the code byte for the next command is
// fetched when the current command completes, so a command never waits on the
// memory. Bad fragments (bit 7 of the count byte set, or more than 255 or
// MAX_CODE_BYTES code bytes) give a single error item flagged last.
// The memory needs no clearing after reset.
module contour_command_decoder_unit
  import ccd_pkg::*;
#(
  parameter int MAX_CODE_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_fragment_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_command_kind,
  output logic [7:0] out_point_x,
  output logic [7:0] out_point_y,
  output logic [7:0] out_first_ctrl_x,
  output logic [7:0] out_first_ctrl_y,
  output logic [7:0] out_second_ctrl_x,
  output logic [7:0] out_second_ctrl_y,
  output logic       out_last_command,
  output logic [1:0] out_error_code
);

  localparam int AW = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
  localparam int CODE_LIMIT = (MAX_CODE_BYTES < CODE_BYTE_CAP) ? MAX_CODE_BYTES
                                                                : CODE_BYTE_CAP;
  localparam logic [12:0] CODE_LIMIT_W = 13'(CODE_LIMIT);

  // control state
  ccd_phase_t  phase_r, phase_nxt;
  logic [13:0] total_r, total_nxt;
  logic [13:0] pos_r, pos_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  cbytes_r, cbytes_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  gather_r [COORD_SLOTS];
  logic [7:0]  gather_nxt [COORD_SLOTS];

  // code-byte memory
  logic [7:0]  code_mem [MAX_CODE_BYTES];
  logic [7:0]  rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_fwd;

  // result being formed
  logic       res_load;
  ccd_cmd_t   res_kind;
  ccd_err_t   res_err;
  logic       res_last;
  logic [7:0] res_px, res_py, res_c1x, res_c1y, res_c2x, res_c2y;

  logic        acc;
  logic        check_count;
  logic [13:0] total_new;
  logic [14:0] total_sum;
  logic [12:0] cbytes_new;
  logic [7:0]  fill_inc;
  logic [2:0]  cnt_inc;
  logic [13:0] pos_inc;
  logic [2:0]  need;
  ccd_cmd_t    cur_kind;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  assign total_new  = in_fragment_start ? {8'd0, in_data_byte[5:0]}
                                        : {total_r[5:0], in_data_byte};
  assign total_sum  = {1'b0, total_new} + 15'd3;
  assign cbytes_new = total_sum[14:2];
  assign fill_inc   = fill_r + 8'd1;
  assign cnt_inc    = cnt_r + 3'd1;
  assign pos_inc    = pos_r + 14'd1;

  // code pair of the current command, least significant pair first
  always_comb begin
    case (pos_r[1:0])
      2'd0:    cur_kind = ccd_cmd_t'(rd_data_r[1:0]);
      2'd1:    cur_kind = ccd_cmd_t'(rd_data_r[3:2]);
      2'd2:    cur_kind = ccd_cmd_t'(rd_data_r[5:4]);
      default: cur_kind = ccd_cmd_t'(rd_data_r[7:6]);
    endcase
    case (cur_kind)
      CMD_QUAD:  need = 3'd4;
      CMD_CUBIC: need = 3'd6;
      default:   need = 3'd2;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    total_nxt   = total_r;
    pos_nxt     = pos_r;
    fill_nxt    = fill_r;
    cbytes_nxt  = cbytes_r;
    cnt_nxt     = cnt_r;
    gather_nxt  = gather_r;
    mem_we      = 1'b0;
    mem_waddr   = AW'(fill_r);
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_fwd      = 1'b0;
    check_count = 1'b0;
    res_load    = 1'b0;
    res_kind    = CMD_MOVE;
    res_err     = ERR_NONE;
    res_last    = 1'b0;
    res_px      = 8'd0;
    res_py      = 8'd0;
    res_c1x     = 8'd0;
    res_c1y     = 8'd0;
    res_c2x     = 8'd0;
    res_c2y     = 8'd0;

    if (acc) begin
      if (in_fragment_start) begin
        if ((in_data_byte & CNT_NOT_CONTOUR) != 8'd0) begin
          res_load  = 1'b1;
          res_err   = ERR_NOT_CONTOUR;
          res_last  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          total_nxt = total_new;
          if ((in_data_byte & CNT_EXTENDED) != 8'd0) begin
            phase_nxt = PH_EXT;
          end else begin
            check_count = 1'b1;
          end
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
          end
          PH_EXT: begin
            total_nxt   = total_new;
            check_count = 1'b1;
          end
          PH_CODES: begin
            mem_we   = 1'b1;
            fill_nxt = fill_inc;
            if (fill_inc >= cbytes_r) begin
              phase_nxt = PH_COORDS;
              cnt_nxt   = 3'd0;
              // fetch the first command's code byte; it may be this very byte
              rd_en     = 1'b1;
              rd_addr   = '0;
              rd_fwd    = (fill_r == 8'd0);
            end
          end
          PH_COORDS: begin
            if (cnt_r < 3'(COORD_SLOTS)) begin
              gather_nxt[cnt_r] = in_data_byte;
            end
            cnt_nxt = cnt_inc;
            if (cnt_inc >= need) begin
              res_load = 1'b1;
              res_kind = cur_kind;
              res_px   = gather_nxt[0];
              res_py   = gather_nxt[1];
              if (cur_kind == CMD_QUAD || cur_kind == CMD_CUBIC) begin
                res_c1x = gather_nxt[2];
                res_c1y = gather_nxt[3];
              end
              if (cur_kind == CMD_CUBIC) begin
                res_c2x = gather_nxt[4];
                res_c2y = gather_nxt[5];
              end
              cnt_nxt = 3'd0;
              pos_nxt = pos_inc;
              rd_en   = 1'b1;
              rd_addr = AW'(pos_inc[13:2]);
              if (pos_inc >= total_r) begin
                res_last  = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end

      if (check_count) begin
        if (cbytes_new > CODE_LIMIT_W) begin
          res_load  = 1'b1;
          res_err   = ERR_COUNT;
          res_last  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          pos_nxt    = 14'd0;
          fill_nxt   = 8'd0;
          cnt_nxt    = 3'd0;
          cbytes_nxt = cbytes_new[7:0];
          phase_nxt  = (total_new == 14'd0) ? PH_IDLE : PH_CODES;
        end
      end
    end

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      total_r     <= 14'd0;
      pos_r       <= 14'd0;
      fill_r      <= 8'd0;
      cbytes_r    <= 8'd0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      cbytes_r    <= cbytes_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gather_r <= gather_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      code_mem[mem_waddr] <= in_data_byte;
    end
    if (rd_en) begin
      rd_data_r <= rd_fwd ? in_data_byte : code_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_command_kind  <= res_kind;
      out_point_x       <= res_px;
      out_point_y       <= res_py;
      out_first_ctrl_x  <= res_c1x;
      out_first_ctrl_y  <= res_c1y;
      out_second_ctrl_x <= res_c2x;
      out_second_ctrl_y <= res_c2y;
      out_last_command  <= res_last;
      out_error_code    <= res_err;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/ccd_checker.sv -----
`include "contour_command_decoder_unit_assert.svh"

module ccd_checker
  import ccd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_fragment_start,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_command_kind,
  input logic [7:0] out_point_x,
  input logic [7:0] out_point_y,
  input logic [7:0] out_first_ctrl_x,
  input logic [7:0] out_first_ctrl_y,
  input logic [7:0] out_second_ctrl_x,
  input logic [7:0] out_second_ctrl_y,
  input logic       out_last_command,
  input logic [1:0] out_error_code
);

  logic err_item;
  logic no_ctrl;
  logic bad_count_in;

  assign err_item = out_valid && out_error_code != ERR_NONE;
  assign no_ctrl  = out_first_ctrl_x == 8'd0 && out_first_ctrl_y == 8'd0 &&
                    out_second_ctrl_x == 8'd0 && out_second_ctrl_y == 8'd0;
  assign bad_count_in = in_valid && !in_stall && in_fragment_start &&
                        in_data_byte[7];

  // an error item ends its fragment and carries no geometry
  `CCD_ASSERT_IMPLY(a_err_shape, err_item,
    out_last_command && out_command_kind == CMD_MOVE && out_point_x == 8'd0 &&
    out_point_y == 8'd0 && no_ctrl, "error item carries data")

  // move and line items have no control points
  `CCD_ASSERT_IMPLY(a_line_no_ctrl,
    out_valid && (out_command_kind == CMD_MOVE || out_command_kind == CMD_LINE),
    no_ctrl, "control point on move or line")

  // input side only backs up behind a held result
  `CCD_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a held result")

  // a non-contour count byte is answered on the next cycle
  `CCD_ASSERT_NEXT(a_not_contour, bad_count_in,
    out_valid && out_error_code == ERR_NOT_CONTOUR, "non-contour fragment not flagged")

endmodule

bind contour_command_decoder_unit ccd_checker u_ccd_checker (.*);

// ----- bench/contour_command_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module contour_command_decoder_unit_tb;
  import ccd_pkg::*;

  localparam int CODE_MEM    = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1800;

  typedef struct packed {
    ccd_cmd_t   kind;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] c1x;
    logic [7:0] c1y;
    logic [7:0] c2x;
    logic [7:0] c2y;
    logic       last;
    ccd_err_t   err;
  } path_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } frag_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_fragment_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_command_kind;
  logic [7:0] out_point_x;
  logic [7:0] out_point_y;
  logic [7:0] out_first_ctrl_x;
  logic [7:0] out_first_ctrl_y;
  logic [7:0] out_second_ctrl_x;
  logic [7:0] out_second_ctrl_y;
  logic       out_last_command;
  logic [1:0] out_error_code;

  contour_command_decoder_unit #(.MAX_CODE_BYTES(CODE_MEM)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_fragment_start (in_fragment_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command_kind  (out_command_kind),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_first_ctrl_x  (out_first_ctrl_x),
    .out_first_ctrl_y  (out_first_ctrl_y),
    .out_second_ctrl_x (out_second_ctrl_x),
    .out_second_ctrl_y (out_second_ctrl_y),
    .out_last_command  (out_last_command),
    .out_error_code    (out_error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frag_byte_t fragment_bytes[$];
  path_cmd_t  expected_commands[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  logic       calm = 1'b0;

  // decoder shadow state
  ccd_phase_t  dec_phase = PH_IDLE;
  logic [13:0] dec_total = '0;
  logic [13:0] dec_pos = '0;
  logic [8:0]  dec_fill = '0;
  logic [7:0]  dec_store [0:CODE_MEM-1];
  logic [47:0] dec_gather = '0;
  logic [2:0]  dec_gathered = '0;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function void push_fault(ccd_err_t code);
    path_cmd_t cmd;
    cmd = '0;
    cmd.last = 1'b1;
    cmd.err = code;
    expected_commands.push_back(cmd);
    dec_phase = PH_IDLE;
  endfunction

  function void settle_count();
    int cbytes;
    cbytes = (int'(dec_total) + 3) / 4;
    if (cbytes > CODE_BYTE_CAP || cbytes > CODE_MEM) begin
      push_fault(ERR_COUNT);
    end else begin
      dec_pos = '0;
      dec_fill = '0;
      dec_gather = '0;
      dec_gathered = '0;
      if (dec_total == 0) dec_phase = PH_IDLE;
      else dec_phase = PH_CODES;
    end
  endfunction

  function void decode_byte(input logic [7:0] b, input logic st);
    path_cmd_t  cmd;
    logic [7:0] code_byte;
    logic [1:0] kind_bits;
    int         idx;
    int         need;
    cmd = '0;
    if (st) begin
      if ((b & CNT_NOT_CONTOUR) != 0) begin
        push_fault(ERR_NOT_CONTOUR);
      end else begin
        dec_total = {8'd0, b[5:0]};
        if ((b & CNT_EXTENDED) != 0) dec_phase = PH_EXT;
        else settle_count();
      end
    end else begin
      case (dec_phase)
        PH_EXT: begin
          dec_total = {dec_total[5:0], b};
          settle_count();
        end
        PH_CODES: begin
          if (dec_fill < CODE_MEM) dec_store[dec_fill] = b;
          dec_fill = dec_fill + 1'b1;
          if (int'(dec_fill) >= (int'(dec_total) + 3) / 4) begin
            dec_phase = PH_COORDS;
            dec_gather = '0;
            dec_gathered = '0;
          end
        end
        PH_COORDS: begin
          idx = int'(dec_pos >> 2);
          code_byte = (idx < CODE_MEM) ? dec_store[idx] : 8'd0;
          kind_bits = 2'(code_byte >> (2 * dec_pos[1:0]));
          cmd.kind = ccd_cmd_t'(kind_bits);
          need = (cmd.kind == CMD_CUBIC) ? 6 : (cmd.kind == CMD_QUAD) ? 4 : 2;
          if (dec_gathered < COORD_SLOTS) dec_gather |= 48'(b) << (8 * dec_gathered);
          dec_gathered = dec_gathered + 1'b1;
          if (dec_gathered >= need) begin
            cmd.px = dec_gather[7:0];
            cmd.py = dec_gather[15:8];
            if (cmd.kind == CMD_QUAD || cmd.kind == CMD_CUBIC) begin
              cmd.c1x = dec_gather[23:16];
              cmd.c1y = dec_gather[31:24];
            end
            if (cmd.kind == CMD_CUBIC) begin
              cmd.c2x = dec_gather[39:32];
              cmd.c2y = dec_gather[47:40];
            end
            dec_pos = dec_pos + 1'b1;
            dec_gather = '0;
            dec_gathered = '0;
            if (dec_pos >= dec_total) begin
              cmd.last = 1'b1;
              dec_phase = PH_IDLE;
            end
            expected_commands.push_back(cmd);
          end
        end
        default: dec_phase = PH_IDLE;
      endcase
    end
  endfunction

  function void add_byte(input logic [7:0] data, input logic start);
    frag_byte_t fb;
    fb.data = data;
    fb.start = start;
    fragment_bytes.push_back(fb);
  endfunction

  function automatic void add_fragment();
    int         pick;
    int         total;
    int         cut;
    int         need;
    logic [7:0] body[$];
    logic [1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // noise: strays and random restarts
      repeat ($urandom_range(1, 6))
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else if (pick < 10) begin
      add_byte(CNT_NOT_CONTOUR | 8'($urandom_range(0, 127)), 1'b1);
    end else if (pick < 13) begin
      total = $urandom_range(1021, 16383);
      add_byte(CNT_EXTENDED | 8'(total >> 8), 1'b1);
      add_byte(8'(total), 1'b0);
    end else if (pick < 16) begin
      if ($urandom_range(0, 1) == 0) begin
        add_byte(8'h00, 1'b1);
      end else begin
        add_byte(CNT_EXTENDED, 1'b1);
        add_byte(8'h00, 1'b0);
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) total = $urandom_range(1, 8);
      else if (pick < 95) total = $urandom_range(9, 63);
      else total = $urandom_range(64, 160);
      if (total > 63 || $urandom_range(0, 9) == 0) begin
        add_byte(CNT_EXTENDED | 8'(total >> 8), 1'b1);
        add_byte(8'(total), 1'b0);
      end else begin
        add_byte(8'(total), 1'b1);
      end
      for (int i = 0; i < (total + 3) / 4; i++) body.push_back(8'($urandom_range(0, 255)));
      for (int c = 0; c < total; c++) begin
        k = 2'(body[c / 4] >> (2 * (c % 4)));
        need = (k == CMD_CUBIC) ? 6 : (k == CMD_QUAD) ? 4 : 2;
        repeat (need) body.push_back(8'($urandom_range(0, 255)));
      end
      // occasionally cut the fragment short; the next count byte restarts
      cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, body.size() - 1) : body.size();
      for (int i = 0; i < cut; i++) add_byte(body[i], 1'b0);
    end
  endfunction

  function void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  frag_byte_t nxt;
  int         gap_left;
  int         wait_now;
  logic       in_fire;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'd0;
      in_fragment_start <= 1'b0;
      gap_left = 0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) decode_byte(in_data_byte, in_fragment_start);
      if (in_fire || !in_valid) begin
        wait_now = in_fire ? draw_wait() : gap_left;
        if (wait_now == 0 && fragment_bytes.size() > 0) begin
          nxt = fragment_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_fragment_start <= nxt.start;
          gap_left = 0;
        end else begin
          in_valid <= 1'b0;
          gap_left = (wait_now == 0) ? 0 : wait_now - 1;
        end
      end
    end
  end

  // monitor
  path_cmd_t want;
  int        hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_commands.size() == 0) begin
          $error("result item with no command expected");
          mismatches++;
        end else begin
          want = expected_commands.pop_front();
          check_field("command_kind", want.kind, out_command_kind);
          check_field("point_x", want.px, out_point_x);
          check_field("point_y", want.py, out_point_y);
          check_field("first_ctrl_x", want.c1x, out_first_ctrl_x);
          check_field("first_ctrl_y", want.c1y, out_first_ctrl_y);
          check_field("second_ctrl_x", want.c2x, out_second_ctrl_x);
          check_field("second_ctrl_y", want.c2y, out_second_ctrl_y);
          check_field("last_command", want.last, out_last_command);
          check_field("error_code", want.err, out_error_code);
        end
        hold = draw_wait();
      end
      out_stall <= (hold != 0);
      if (hold != 0) hold = hold - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    // switch at random between stretches of random idling and stretches of none
    if (cycle_count % 256 == 255) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  int directed_count;

  initial begin
    rst_n = 1'b0;

    // strays while idle, non-contour, zero counts
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(CNT_EXTENDED, 1'b1);
    add_byte(8'h00, 1'b0);
    // 1021 commands needs 256 code bytes: too large
    add_byte(8'h43, 1'b1);
    add_byte(8'hFD, 1'b0);
    // 1020 commands fits; abandon it after two code bytes
    add_byte(8'h43, 1'b1);
    add_byte(8'hFC, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    // restart into one of each kind: move, line, quad, cubic
    add_byte(8'h04, 1'b1);
    add_byte(8'hE4, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b0);
    add_byte(8'h56, 1'b0);
    add_byte(8'h78, 1'b0);
    directed_count = fragment_bytes.size();
    while (fragment_bytes.size() < directed_count + RANDOM_BYTES) add_fragment();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (fragment_bytes.size() > 0 || in_valid || expected_commands.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (expected_commands.size() != 0) begin
      $error("%0d expected commands never arrived", expected_commands.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
